// ===== hdl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, widths and constants of the polyline segment subdivider.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int MAX_PIECES = 32;
    localparam int LIM_BITS   = 20;

    localparam int OUT_W  = COORD_BITS + FRAC_BITS;
    localparam int D2_W   = 2 * COORD_BITS + 1;
    localparam int ROOT_W = COORD_BITS + FRAC_BITS + 1;
    localparam int PK_W   = $clog2(MAX_PIECES + 1);
    localparam int T_W    = ROOT_W + PK_W;
    localparam int PROD_W = OUT_W + T_W;
    localparam int DIV_W  = (ROOT_W > LIM_BITS) ? ROOT_W : LIM_BITS;

    localparam logic [LIM_BITS-1:0] LIM_RESET = LIM_BITS'(2560);
    localparam logic [OUT_W-1:0]    OUT_MAX   = {OUT_W{1'b1}};

    typedef struct packed {
        logic [COORD_BITS-1:0] vertex_x;
        logic [COORD_BITS-1:0] vertex_y;
        logic                  contour_end;
    } in_t;

    typedef struct packed {
        logic [OUT_W-1:0] point_x;
        logic [OUT_W-1:0] point_y;
        logic             run_last;
        logic             pieces_clipped;
    } out_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [PROD_W-1:0] quotient;
        logic [DIV_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// ===== hdl/polyline_segment_subdivider.sv =====
// ----------------------------------------------------------------------------
// polyline_segment_subdivider
// Densifies contours: splits edges longer than max_edge_length into pieces.
// ----------------------------------------------------------------------------
// Vertices arrive on the s_ channel (valid/ready), the final vertex of each
// contour flagged by contour_end. Points leave on the m_ channel, run_last
// marking the last point caused by one vertex. max_edge_length is written
// through cfg_we/cfg_data; the user writes it only while the block is idle,
// the block itself does not enforce this. One vertex is taken at a time;
// s_ready is low until all its points have been handed to the output
// register. A short edge costs one square root of ROOT_W = 21 result bits.
// A long edge adds two divisions of PROD_W = 47 quotient bits each, then
// two more per interior point, as both axes go through the one shared
// restoring divider; an edge is split into at most 32 pieces.
// Reset clears the held vertex and the output valid flag and restores
// max_edge_length to 2560. A stalled receiver holds the output register,
// and the sequencer waits with it; nothing is lost.
// ----------------------------------------------------------------------------
module polyline_segment_subdivider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pss_pkg::in_t                     s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pss_pkg::out_t                    m_data,
    input  logic                             cfg_we,
    input  logic [pss_pkg::LIM_BITS-1:0]     cfg_data
);
    import pss_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQGO   = 4'd1;
    localparam logic [3:0] ST_SQWAIT = 4'd2;
    localparam logic [3:0] ST_PCWAIT = 4'd3;
    localparam logic [3:0] ST_SPWAIT = 4'd4;
    localparam logic [3:0] ST_ESTART = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_DGO    = 4'd7;
    localparam logic [3:0] ST_DWAIT  = 4'd8;
    localparam logic [3:0] ST_EINT   = 4'd9;
    localparam logic [3:0] ST_EEND   = 4'd10;
    localparam logic [3:0] ST_ESHORT = 4'd11;
    localparam logic [3:0] ST_TAIL   = 4'd12;

    logic [3:0]            st_reg, st_next;
    logic [LIM_BITS-1:0]   lim_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg, cx_reg, cy_reg;
    logic                  have_prev_reg, end_reg, clip_reg, axis_reg;
    logic [D2_W-1:0]       d2_reg;
    logic [ROOT_W-1:0]     root_reg, spacing_reg;
    logic                  rem_nz_reg;
    logic [PK_W-1:0]       pieces_reg, k_reg;
    logic [T_W-1:0]        t_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [OUT_W-1:0]      ix_reg, iy_reg;
    logic                  out_valid_reg;
    out_t                  out_reg;

    logic                  sq_start, sq_busy, sq_rem_nz;
    logic [ROOT_W-1:0]     sq_root;
    div_req_t              dreq;
    div_rsp_t              drsp;

    logic [COORD_BITS-1:0] adx, ady;
    logic [D2_W-1:0]       d2_in;
    logic [DIV_W-1:0]      lim_ext, root_ext;
    logic                  is_long, out_free, round_up, ceil_inc;
    logic                  emit_point;
    logic [PROD_W:0]       q_ceil, off;
    logic [PK_W-1:0]       pieces_sat;
    logic                  pieces_over;
    logic [COORD_BITS-1:0] a_from, a_to;
    logic [OUT_W-1:0]      a_start, a_mag, a_val;

    pss_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .d2      (d2_reg),
        .busy    (sq_busy),
        .root    (sq_root),
        .rem_nz  (sq_rem_nz)
    );

    pss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    always_comb begin
        adx = (s_data.vertex_x >= px_reg) ? s_data.vertex_x - px_reg
                                          : px_reg - s_data.vertex_x;
        ady = (s_data.vertex_y >= py_reg) ? s_data.vertex_y - py_reg
                                          : py_reg - s_data.vertex_y;
        d2_in = D2_W'(adx) * D2_W'(adx) + D2_W'(ady) * D2_W'(ady);

        lim_ext  = (lim_reg == '0) ? DIV_W'(1) : DIV_W'(lim_reg);
        root_ext = DIV_W'(sq_root);
        is_long  = (root_ext > lim_ext) || ((root_ext == lim_ext) && sq_rem_nz);

        // Ceiling of the exact root over the divisor.
        ceil_inc = (drsp.remainder != '0) || rem_nz_reg;
        q_ceil   = {1'b0, drsp.quotient} + (PROD_W + 1)'(ceil_inc);
        pieces_over = (q_ceil > (PROD_W + 1)'(MAX_PIECES));
        pieces_sat  = pieces_over ? PK_W'(MAX_PIECES) : q_ceil[PK_W-1:0];

        round_up = ({drsp.remainder, 1'b0} >= {1'b0, dreq.divisor});
        off      = {1'b0, drsp.quotient} + (PROD_W + 1)'(round_up);

        a_from  = axis_reg ? py_reg : px_reg;
        a_to    = axis_reg ? cy_reg : cx_reg;
        a_start = {a_from, {FRAC_BITS{1'b0}}};
        a_mag   = (a_to >= a_from) ? {a_to - a_from, {FRAC_BITS{1'b0}}}
                                   : {a_from - a_to, {FRAC_BITS{1'b0}}};
        if (a_to >= a_from) begin
            if (off > (PROD_W + 1)'(OUT_MAX - a_start)) begin
                a_val = OUT_MAX;
            end else begin
                a_val = a_start + off[OUT_W-1:0];
            end
        end else begin
            if (off > (PROD_W + 1)'(a_start)) begin
                a_val = '0;
            end else begin
                a_val = a_start - off[OUT_W-1:0];
            end
        end

        dreq.start    = 1'b0;
        dreq.dividend = prod_reg;
        dreq.divisor  = root_ext;
        unique case (st_reg)
            ST_SQWAIT: begin
                dreq.start    = !sq_busy && is_long;
                dreq.dividend = PROD_W'(sq_root);
                dreq.divisor  = lim_ext;
            end
            ST_PCWAIT: begin
                dreq.start    = !drsp.busy;
                dreq.dividend = PROD_W'(root_reg);
                dreq.divisor  = DIV_W'(pieces_sat);
            end
            ST_SPWAIT: begin
                dreq.dividend = PROD_W'(root_reg);
                dreq.divisor  = DIV_W'(pieces_reg);
            end
            ST_DGO: begin
                dreq.start    = 1'b1;
                dreq.divisor  = DIV_W'(root_reg);
            end
            ST_DWAIT: begin
                dreq.divisor  = DIV_W'(root_reg);
            end
            default: begin
                dreq.start = 1'b0;
            end
        endcase

        sq_start = (st_reg == ST_SQGO);
        out_free = !out_valid_reg || m_ready;
        emit_point = out_free && ((st_reg == ST_ESTART) || (st_reg == ST_ESHORT) ||
                                  (st_reg == ST_EINT) || (st_reg == ST_EEND) ||
                                  ((st_reg == ST_TAIL) && end_reg));
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:   if (s_valid) st_next = have_prev_reg ? ST_SQGO : ST_TAIL;
            ST_SQGO:   st_next = ST_SQWAIT;
            ST_SQWAIT: if (!sq_busy) st_next = is_long ? ST_PCWAIT : ST_ESHORT;
            ST_PCWAIT: if (!drsp.busy) st_next = ST_SPWAIT;
            ST_SPWAIT: if (!drsp.busy) st_next = ST_ESTART;
            ST_ESTART: if (out_free) st_next = ST_MUL;
            ST_MUL:    st_next = ST_DGO;
            ST_DGO:    st_next = ST_DWAIT;
            ST_DWAIT:  if (!drsp.busy) st_next = axis_reg ? ST_EINT : ST_MUL;
            ST_EINT: begin
                if (out_free) begin
                    st_next = (k_reg + 1'b1 == pieces_reg) ? ST_EEND : ST_MUL;
                end
            end
            ST_EEND:   if (out_free) st_next = ST_TAIL;
            ST_ESHORT: if (out_free) st_next = ST_TAIL;
            ST_TAIL:   if (!end_reg || out_free) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && s_valid) begin
            cx_reg  <= s_data.vertex_x;
            cy_reg  <= s_data.vertex_y;
            end_reg <= s_data.contour_end;
            d2_reg  <= d2_in;
        end
        if (st_reg == ST_SQWAIT && !sq_busy) begin
            root_reg   <= sq_root;
            rem_nz_reg <= sq_rem_nz;
        end
        if (st_reg == ST_PCWAIT && !drsp.busy) begin
            pieces_reg <= pieces_sat;
        end
        if (st_reg == ST_SPWAIT && !drsp.busy) begin
            spacing_reg <= q_ceil[ROOT_W-1:0];
            t_reg       <= T_W'(q_ceil[ROOT_W-1:0]);
            k_reg       <= PK_W'(1);
        end
        if (st_reg == ST_MUL) begin
            prod_reg <= PROD_W'(a_mag) * PROD_W'(t_reg);
        end
        if (st_reg == ST_DWAIT && !drsp.busy) begin
            if (axis_reg) begin
                iy_reg <= a_val;
            end else begin
                ix_reg <= a_val;
            end
        end
        if (st_reg == ST_EINT && out_free) begin
            k_reg <= k_reg + 1'b1;
            t_reg <= t_reg + T_W'(spacing_reg);
        end

        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            lim_reg       <= LIM_RESET;
            px_reg        <= '0;
            py_reg        <= '0;
            have_prev_reg <= 1'b0;
            clip_reg      <= 1'b0;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) begin
                lim_reg <= cfg_data;
            end
            if (st_reg == ST_IDLE && s_valid) begin
                clip_reg <= 1'b0;
            end
            if (st_reg == ST_PCWAIT && !drsp.busy) begin
                clip_reg <= pieces_over;
            end
            if (st_reg == ST_ESTART) begin
                axis_reg <= 1'b0;
            end
            if (st_reg == ST_DWAIT && !drsp.busy) begin
                axis_reg <= !axis_reg;
            end
            if (st_reg == ST_TAIL && st_next == ST_IDLE) begin
                have_prev_reg <= !end_reg;
                if (!end_reg) begin
                    px_reg <= cx_reg;
                    py_reg <= cy_reg;
                end
            end

            if (emit_point) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (out_free) begin
                priority case (st_reg)
                    ST_ESTART, ST_ESHORT: begin
                        out_reg.point_x        <= {px_reg, {FRAC_BITS{1'b0}}};
                        out_reg.point_y        <= {py_reg, {FRAC_BITS{1'b0}}};
                        out_reg.run_last       <= (st_reg == ST_ESHORT) && !end_reg;
                        out_reg.pieces_clipped <= clip_reg;
                    end
                    ST_EINT: begin
                        out_reg.point_x        <= ix_reg;
                        out_reg.point_y        <= iy_reg;
                        out_reg.run_last       <= 1'b0;
                        out_reg.pieces_clipped <= clip_reg;
                    end
                    ST_EEND, ST_TAIL: begin
                        if (st_reg == ST_EEND || end_reg) begin
                            out_reg.point_x        <= {cx_reg, {FRAC_BITS{1'b0}}};
                            out_reg.point_y        <= {cy_reg, {FRAC_BITS{1'b0}}};
                            out_reg.run_last       <= (st_reg == ST_TAIL) || !end_reg;
                            out_reg.pieces_clipped <= clip_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign s_ready = (st_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== hdl/pss_sqrt.sv =====
// ----------------------------------------------------------------------------
// pss_sqrt
// Digit-by-digit square root of d2 * 4^FRAC_BITS, one result bit per cycle.
// ----------------------------------------------------------------------------
module pss_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [pss_pkg::D2_W-1:0]  d2,
    output logic                      busy,
    output logic [pss_pkg::ROOT_W-1:0] root,
    output logic                      rem_nz
);
    import pss_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W+1:0]   m_reg, m_next;
    logic [ROOT_W-1:0]   r_reg, r_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [ROOT_W+1:0]   m_sh, trial;

    always_comb begin
        m_sh  = {m_reg[ROOT_W-1:0], rad_reg[2*ROOT_W-1 -: 2]};
        trial = {r_reg, 2'b01};
        rad_next  = rad_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rad_next  = {1'b0, d2, {(2*FRAC_BITS){1'b0}}};
            m_next    = '0;
            r_next    = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = rad_reg << 2;
            if (m_sh >= trial) begin
                m_next = m_sh - trial;
                r_next = {r_reg[ROOT_W-2:0], 1'b1};
            end else begin
                m_next = m_sh;
                r_next = {r_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg <= rad_next;
        m_reg   <= m_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign busy   = busy_reg;
    assign root   = r_reg;
    assign rem_nz = (m_reg != '0);

endmodule

// ===== hdl/pss_div.sv =====
// ----------------------------------------------------------------------------
// pss_div
// Restoring divider shared by every division of the block, one bit a cycle.
// ----------------------------------------------------------------------------
module pss_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  pss_pkg::div_req_t req,
    output pss_pkg::div_rsp_t rsp
);
    import pss_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0]  r_reg, r_next;
    logic [DIV_W-1:0]  d_reg, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DIV_W:0]    sh;

    always_comb begin
        sh = {r_reg, q_reg[PROD_W-1]};
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start) begin
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
            cnt_next  = CNT_W'(PROD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, d_reg}) begin
                r_next = DIV_W'(sh - {1'b0, d_reg});
                q_next = {q_reg[PROD_W-2:0], 1'b1};
            end else begin
                r_next = sh[DIV_W-1:0];
                q_next = {q_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

// ===== hdl/pss_checker.sv =====
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks of the subdivider, bound to the top level.
// ----------------------------------------------------------------------------
module pss_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input pss_pkg::out_t m_data
);
    import pss_pkg::*;

    // A held result stays on the port until the receiver takes it.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // The block works on one vertex at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // Reset leaves the block empty and ready for a vertex.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

endmodule

bind polyline_segment_subdivider pss_checker u_pss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
